// ----- design/sth_pkg.sv -----
package sth_pkg;

    localparam int STAMP_OCTETS = 7;
    localparam int STAMP_W      = 3;
    localparam int MAX_RESULTS  = 2;

    typedef enum logic [3:0] {
        KIND_FIRST = 4'd0,
        KIND_REF   = 4'd1,
        KIND_ACNT  = 4'd2,
        KIND_ATYPE = 4'd3,
        KIND_DIGIT = 4'd4,
        KIND_PID   = 4'd5,
        KIND_DCS   = 4'd6,
        KIND_SCTS  = 4'd7,
        KIND_DT    = 4'd8,
        KIND_ST    = 4'd9,
        KIND_FCS   = 4'd10,
        KIND_UDL   = 4'd11,
        KIND_END   = 4'd12
    } field_kind_t;

    typedef enum logic [1:0] {
        MT_DELIVER       = 2'd0,
        MT_SUBMIT_REPORT = 2'd1,
        MT_STATUS_REPORT = 2'd2,
        MT_INVALID       = 2'd3
    } msg_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_BAD_DIGIT = 2'd3
    } status_t;

    typedef struct packed {
        field_kind_t kind;
        logic [7:0]  value;
        logic [3:0]  digit_low;
        logic [3:0]  digit_high;
        logic [1:0]  digit_count;
        logic [1:0]  message_type;
        status_t     status;
        logic [7:0]  header_length;
        logic        end_of_header;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first_res;
        result_t    second_res;
    } push_t;

endpackage

// ----- design/sms_tpdu_header_decoder.sv -----
// Channel | Dir | tdata                                   | tuser      | tlast
// s_      | in  | [7:0] tpdu_byte                         | -          | final_byte
// m_      | out | [7:0] field_value, [11:8] digit_low,    | field_kind | end_of_header
//         |     | [15:12] digit_high, [17:16] digit_count,|            |
//         |     | [19:18] message_type, [21:20] status,   |            |
//         |     | [29:22] header_length, [31:30] zero     |            |
//
// One word a cycle enters while s_tready is high; it is decoded while held in the input register.
// A word gives zero, one or two results; the two-slot result queue drains one a cycle while
// m_tready is high, so a word that gives two results leaves as two m_ words.
// An accepted byte passes the input register, then the result queue, before it reaches m_.
// Reset clears parse state and the valid flags of both queue slots; no clearing pass.
// Stalls on m_ back up through the queue to s_tready.
module sms_tpdu_header_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] tpdu_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value, digit_low, digit_high, digit_count, type, status, len
    output logic [3:0]  m_tuser,   // [3:0] field_kind
    output logic        m_tlast
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_fin_reg;
    logic             consume;
    logic [1:0]       free_slots;
    sth_pkg::push_t   push;
    sth_pkg::result_t head;

    assign consume  = in_valid_reg && (push.count <= free_slots);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_fin_reg  <= s_tlast;
        end
    end

    sth_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .in_fin   (in_fin_reg),
        .consume  (consume),
        .push     (push)
    );

    sth_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (consume),
        .push       (push),
        .free_slots (free_slots),
        .head_valid (m_tvalid),
        .head       (head),
        .head_ready (m_tready)
    );

    assign m_tdata = {2'b00, head.header_length, head.status, head.message_type,
                      head.digit_count, head.digit_high, head.digit_low, head.value};
    assign m_tuser = head.kind;
    assign m_tlast = head.end_of_header;

    a_end_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == sth_pkg::KIND_END |-> m_tlast && m_tdata[29:22] != 8'd0)
        else $error("end summary without tlast or with zero header length");

    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == sth_pkg::KIND_DIGIT
            |-> m_tdata[17:16] == 2'd1 || m_tdata[17:16] == 2'd2)
        else $error("digit word without digits");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !consume |=> in_valid_reg && $stable(in_byte_reg))
        else $error("pending input word lost");

endmodule

// ----- design/sth_parser.sv -----
module sth_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_fin,
    input  logic            consume,
    output sth_pkg::push_t  push
);

    typedef enum logic [3:0] {
        PH_FIRST  = 4'd0,
        PH_REF    = 4'd1,
        PH_ACNT   = 4'd2,
        PH_ATYPE  = 4'd3,
        PH_DIGITS = 4'd4,
        PH_PID    = 4'd5,
        PH_DCS    = 4'd6,
        PH_SCTS   = 4'd7,
        PH_DT     = 4'd8,
        PH_ST     = 4'd9,
        PH_FCS    = 4'd10,
        PH_UDL    = 4'd11
    } phase_t;

    localparam logic [sth_pkg::STAMP_W-1:0] STAMP_LOAD = sth_pkg::STAMP_W'(sth_pkg::STAMP_OCTETS);

    phase_t                      phase_reg, phase_next;
    logic [1:0]                  kind_held_reg, kind_held_next;
    logic [7:0]                  addr_left_reg, addr_left_next;
    logic [sth_pkg::STAMP_W-1:0] stamp_left_reg, stamp_left_next;
    logic [7:0]                  consumed_reg, consumed_next;
    logic                        finished_reg, finished_next;

    logic [7:0]           consumed_inc;
    logic                 emit, done, last_pair, bad;
    logic [3:0]           lo, hi;
    logic [3:0]           dl, dh;
    logic [1:0]           dc;
    logic [1:0]           mtype;
    sth_pkg::status_t     status;
    sth_pkg::field_kind_t kind;
    sth_pkg::result_t     field_res, end_res;

    always_comb begin
        phase_next      = phase_reg;
        kind_held_next  = kind_held_reg;
        addr_left_next  = addr_left_reg;
        stamp_left_next = stamp_left_reg;
        consumed_next   = consumed_reg;
        finished_next   = finished_reg;
        consumed_inc    = consumed_reg + 8'd1;
        emit            = 1'b1;
        done            = 1'b0;
        status          = sth_pkg::ST_OK;
        kind            = sth_pkg::KIND_FIRST;
        dl              = 4'd0;
        dh              = 4'd0;
        dc              = 2'd0;
        mtype           = kind_held_reg;
        lo              = in_byte[3:0];
        hi              = in_byte[7:4];
        last_pair       = (addr_left_reg <= 8'd1);
        bad             = 1'b0;

        if (finished_reg) begin
            emit = 1'b0;
        end else begin
            consumed_next = consumed_inc;
            case (phase_reg)
                PH_REF: begin
                    kind       = sth_pkg::KIND_REF;
                    phase_next = PH_ACNT;
                end
                PH_ACNT: begin
                    kind           = sth_pkg::KIND_ACNT;
                    addr_left_next = {1'b0, in_byte[7:1]} + {7'd0, in_byte[0]};
                    phase_next     = PH_ATYPE;
                end
                PH_ATYPE: begin
                    kind = sth_pkg::KIND_ATYPE;
                    if (addr_left_reg != 8'd0) begin
                        phase_next = PH_DIGITS;
                    end else if (kind_held_reg == sth_pkg::MT_STATUS_REPORT) begin
                        phase_next      = PH_SCTS;
                        stamp_left_next = STAMP_LOAD;
                    end else begin
                        phase_next = PH_PID;
                    end
                end
                PH_DIGITS: begin
                    kind = sth_pkg::KIND_DIGIT;
                    if (lo > 4'd9) begin
                        bad = 1'b1;
                    end else if (hi == 4'hF && last_pair) begin
                        dc = 2'd1;
                    end else if (hi > 4'd9) begin
                        bad = 1'b1;
                    end else begin
                        dc = 2'd2;
                    end
                    if (bad) begin
                        status = sth_pkg::ST_BAD_DIGIT;
                        done   = 1'b1;
                        emit   = 1'b0;
                        dc     = 2'd0;
                    end else begin
                        dl = lo;
                        dh = (dc == 2'd2) ? hi : 4'd0;
                        if (last_pair) begin
                            addr_left_next = 8'd0;
                            if (kind_held_reg == sth_pkg::MT_STATUS_REPORT) begin
                                phase_next      = PH_SCTS;
                                stamp_left_next = STAMP_LOAD;
                            end else begin
                                phase_next = PH_PID;
                            end
                        end else begin
                            addr_left_next = addr_left_reg - 8'd1;
                        end
                    end
                end
                PH_PID: begin
                    kind       = sth_pkg::KIND_PID;
                    phase_next = PH_DCS;
                end
                PH_DCS: begin
                    kind            = sth_pkg::KIND_DCS;
                    phase_next      = PH_SCTS;
                    stamp_left_next = STAMP_LOAD;
                end
                PH_SCTS: begin
                    kind = sth_pkg::KIND_SCTS;
                    if (stamp_left_reg <= sth_pkg::STAMP_W'(1)) begin
                        if (kind_held_reg == sth_pkg::MT_STATUS_REPORT) begin
                            phase_next      = PH_DT;
                            stamp_left_next = STAMP_LOAD;
                        end else begin
                            phase_next      = PH_UDL;
                            stamp_left_next = '0;
                        end
                    end else begin
                        stamp_left_next = stamp_left_reg - sth_pkg::STAMP_W'(1);
                    end
                end
                PH_DT: begin
                    kind = sth_pkg::KIND_DT;
                    if (stamp_left_reg <= sth_pkg::STAMP_W'(1)) begin
                        phase_next      = PH_ST;
                        stamp_left_next = '0;
                    end else begin
                        stamp_left_next = stamp_left_reg - sth_pkg::STAMP_W'(1);
                    end
                end
                PH_ST: begin
                    kind = sth_pkg::KIND_ST;
                    done = 1'b1;
                end
                PH_FCS: begin
                    kind = sth_pkg::KIND_FCS;
                    done = 1'b1;
                end
                PH_UDL: begin
                    kind = sth_pkg::KIND_UDL;
                    done = 1'b1;
                end
                default: begin
                    kind           = sth_pkg::KIND_FIRST;
                    kind_held_next = in_byte[1:0];
                    mtype          = in_byte[1:0];
                    case (in_byte[1:0])
                        sth_pkg::MT_INVALID: begin
                            status = sth_pkg::ST_BAD_TYPE;
                            done   = 1'b1;
                        end
                        sth_pkg::MT_DELIVER:       phase_next = PH_ACNT;
                        sth_pkg::MT_SUBMIT_REPORT: phase_next = PH_FCS;
                        default:                   phase_next = PH_REF;
                    endcase
                end
            endcase

            if (!done && in_fin) begin
                status = sth_pkg::ST_SHORT;
                done   = 1'b1;
            end
            if (done) begin
                finished_next = 1'b1;
            end
        end

        if (in_fin && (finished_reg || done)) begin
            phase_next      = PH_FIRST;
            kind_held_next  = 2'd0;
            addr_left_next  = 8'd0;
            stamp_left_next = '0;
            consumed_next   = 8'd0;
            finished_next   = 1'b0;
        end

        field_res = '{kind: kind, value: in_byte, digit_low: dl, digit_high: dh,
                      digit_count: dc, message_type: mtype, status: sth_pkg::ST_OK,
                      header_length: 8'd0, end_of_header: 1'b0};
        end_res   = '{kind: sth_pkg::KIND_END, value: 8'd0, digit_low: 4'd0,
                      digit_high: 4'd0, digit_count: 2'd0, message_type: mtype,
                      status: status, header_length: consumed_inc, end_of_header: 1'b1};

        push.count      = {1'b0, emit} + {1'b0, done};
        push.first_res  = emit ? field_res : end_res;
        push.second_res = end_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_FIRST;
            kind_held_reg  <= 2'd0;
            addr_left_reg  <= 8'd0;
            stamp_left_reg <= '0;
            consumed_reg   <= 8'd0;
            finished_reg   <= 1'b0;
        end else if (in_valid && consume) begin
            phase_reg      <= phase_next;
            kind_held_reg  <= kind_held_next;
            addr_left_reg  <= addr_left_next;
            stamp_left_reg <= stamp_left_next;
            consumed_reg   <= consumed_next;
            finished_reg   <= finished_next;
        end
    end

endmodule

// ----- design/sth_result_queue.sv -----
module sth_result_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_en,
    input  sth_pkg::push_t    push,
    output logic [1:0]        free_slots,
    output logic              head_valid,
    output sth_pkg::result_t  head,
    input  logic              head_ready
);

    sth_pkg::result_t slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic             v0_reg, v0_next, v1_reg, v1_next;
    logic             pop;

    always_comb begin
        pop        = v0_reg && head_ready;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        v0_next    = v0_reg;
        v1_next    = v1_reg;

        // shift up on pop
        if (pop) begin
            slot0_next = slot1_reg;
            v0_next    = v1_reg;
            v1_next    = 1'b0;
        end

        free_slots = {1'b0, !v0_next} + {1'b0, !v1_next};

        if (push_en && push.count != 2'd0) begin
            if (!v0_next) begin
                slot0_next = push.first_res;
                v0_next    = 1'b1;
                if (push.count == 2'd2) begin
                    slot1_next = push.second_res;
                    v1_next    = 1'b1;
                end
            end else begin
                slot1_next = push.first_res;
                v1_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign head_valid = v0_reg;
    assign head       = slot0_reg;

endmodule
